FILE: design/rcsfr_pkg.sv
// Shared types and constants of the serial frame receiver.
package rcsfr_pkg;

   localparam int CHANNELS    = 14;
   localparam int FRAME_BYTES = 2 * CHANNELS;
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W       = $clog2(FRAME_BYTES + 1);
   localparam int ADDR_W      = 4;

   localparam logic [7:0]  HEADER_RESET = 8'd64;
   localparam logic [31:0] GAP_RESET    = 32'd3000;
   localparam logic [31:0] ALIVE_RESET  = 32'd1000000;

   // item kinds
   localparam logic KIND_POLL = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   // result event codes
   localparam logic [1:0] EV_CHANNEL = 2'd0;
   localparam logic [1:0] EV_ERROR   = 2'd1;
   localparam logic [1:0] EV_POLL    = 2'd2;

   // register indexes
   localparam logic [1:0] REG_HEADER = 2'd0;
   localparam logic [1:0] REG_GAP    = 2'd1;
   localparam logic [1:0] REG_ALIVE  = 2'd2;

   typedef enum logic [2:0] {
      PH_DISCARD,
      PH_HUNT,
      PH_DATA,
      PH_CKL,
      PH_CKH
   } phase_type;

   typedef enum logic [1:0] {
      CT_IDLE,
      CT_EXEC,
      CT_READ,
      CT_SEND
   } ctl_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_value;
      logic [31:0] time_now;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [3:0]  channel_index;
      logic [15:0] channel_value;
      logic        last_of_frame;
      logic        link_alive;
   } rsp_type;

endpackage

FILE: design/rc_serial_frame_receiver.sv
// Top level of the radio-control serial frame receiver.
//
// Usage: one transaction on the req_ channel is either a poll carrying the
// current microsecond time or one received serial byte. Results leave on the
// rsp_ channel: a poll status for every poll, one checksum error for a bad
// frame, or CHANNELS channel words in order for a good frame.
// Sequencing: each item is captured in the input register, then executed by
// the control sequencer; no new item is taken before the sequencer is idle.
// Results: a poll status or an error is valid the edge after the execute
// cycle. A good frame is walked out of the word memory one channel at a
// time (read, then send; a send waits for rsp_ready while the output is full);
// no transaction is taken during the walk.
// Stall: the output register holds a result until rsp_ready; a new item is
// still captured then, and only a poll or checksum byte waits for the output.
// Reset: the parser sits in discard until the first poll, no good frame has
// been seen, and the registers take their default values. The word memory
// needs no clearing pass: a frame is written in full before it is read.
// Configuration: APB writes at byte addresses 0, 4 and 8; issue them only
// while the block is idle.
module rc_serial_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rcsfr_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rcsfr_pkg::rsp_type            rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rcsfr_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import rcsfr_pkg::*;

   // configuration registers
   logic [7:0]  header_ff;
   logic [31:0] gap_ff;
   logic [31:0] alive_ff;
   logic        cfg_we;
   logic [1:0]  cfg_idx;

   // control sequencer
   ctl_type ctl_ff, ctl_in;

   // captured item
   req_type item_ff;

   // parser state
   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]       sum_ff, sum_in;
   logic [7:0]        ck_low_ff, ck_low_in;
   logic [7:0]        low_hold_ff, low_hold_in;
   logic [31:0]       last_good_ff, last_good_in;
   logic              never_good_ff, never_good_in;
   logic [31:0]       poll_time_ff, poll_time_in;
   logic [CH_W-1:0]   rd_idx_ff, rd_idx_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // word memory: one 16-bit channel word per entry
   logic [15:0]     frame_mem [CHANNELS];
   logic [15:0]     mem_q_ff;
   logic            mem_we;
   logic [CH_W-1:0] mem_wr_idx;

   // control strobes
   logic        out_free;
   logic        needs_slot;
   logic        is_ckh_byte;
   logic        checksum_ok;
   logic        exec_go;
   logic        mem_rd_en;
   logic        send_go;
   logic        last_word;
   logic [31:0] elapsed;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign cfg_idx = paddr[3:2];
   assign cfg_we  = psel & penable & pwrite;

   always_comb begin
      unique case (cfg_idx)
         REG_HEADER: prdata = {24'd0, header_ff};
         REG_GAP:    prdata = gap_ff;
         REG_ALIVE:  prdata = alive_ff;
         default:    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         gap_ff    <= GAP_RESET;
         alive_ff  <= ALIVE_RESET;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            REG_HEADER: header_ff <= pwdata[7:0];
            REG_GAP:    gap_ff    <= pwdata;
            REG_ALIVE:  alive_ff  <= pwdata;
            default:    ; // no register here: drop the write
         endcase
      end
   end

   // ---------------- decisions on the captured item ----------------
   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign is_ckh_byte = (item_ff.kind == KIND_BYTE) && (phase_ff == PH_CKH);
   // polls and the final checksum byte need a free output slot to execute
   assign needs_slot  = (item_ff.kind == KIND_POLL) || is_ckh_byte;
   assign checksum_ok = (sum_ff == {item_ff.byte_value, ck_low_ff});
   assign elapsed     = item_ff.time_now - last_good_ff;
   assign last_word   = (rd_idx_ff == CH_W'(CHANNELS - 1));

   // ---------------- sequencer: next state ----------------
   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         CT_IDLE: begin
            if (req_valid) ctl_in = CT_EXEC;
         end
         CT_EXEC: begin
            if (!needs_slot || out_free) begin
               if (is_ckh_byte && checksum_ok) ctl_in = CT_READ;
               else                            ctl_in = CT_IDLE;
            end
         end
         CT_READ: ctl_in = CT_SEND;
         CT_SEND: begin
            if (out_free) ctl_in = last_word ? CT_IDLE : CT_READ;
         end
         default: ctl_in = CT_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_ready = 1'b0;
      exec_go   = 1'b0;
      mem_rd_en = 1'b0;
      send_go   = 1'b0;
      unique case (ctl_ff)
         CT_IDLE: req_ready = 1'b1;
         CT_EXEC: exec_go   = ~needs_slot | out_free;
         CT_READ: mem_rd_en = 1'b1;
         CT_SEND: send_go   = out_free;
         default: ;
      endcase
   end

   // ---------------- parser datapath ----------------
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      ck_low_in     = ck_low_ff;
      low_hold_in   = low_hold_ff;
      last_good_in  = last_good_ff;
      never_good_in = never_good_ff;
      poll_time_in  = poll_time_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      mem_we        = 1'b0;
      mem_wr_idx    = pos_ff[CH_W:1];

      if (exec_go) begin
         if (item_ff.kind == KIND_POLL) begin
            poll_time_in = item_ff.time_now;
            if (never_good_ff || (elapsed >= gap_ff)) phase_in = PH_HUNT;
            rsp_valid_in             = 1'b1;
            rsp_data_in              = '0;
            rsp_data_in.event_res    = EV_POLL;
            rsp_data_in.link_alive   = ~never_good_ff && (elapsed < alive_ff);
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (item_ff.byte_value == header_ff) begin
                     pos_in   = '0;
                     sum_in   = '0;
                     phase_in = PH_DATA;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end
               PH_DATA: begin
                  // even position: low byte, hold it; odd: write the word
                  if (pos_ff[0]) begin
                     mem_we = 1'b1;
                     sum_in = sum_ff + {item_ff.byte_value, 8'd0};
                  end else begin
                     low_hold_in = item_ff.byte_value;
                     sum_in      = sum_ff + {8'd0, item_ff.byte_value};
                  end
                  pos_in = pos_ff + POS_W'(1);
                  if (pos_in == POS_W'(FRAME_BYTES)) phase_in = PH_CKL;
               end
               PH_CKL: begin
                  ck_low_in = item_ff.byte_value;
                  phase_in  = PH_CKH;
               end
               PH_CKH: begin
                  if (checksum_ok) begin
                     last_good_in  = poll_time_ff;
                     never_good_in = 1'b0;
                     phase_in      = PH_HUNT;
                     rd_idx_in     = '0;
                  end else begin
                     phase_in              = PH_DISCARD;
                     rsp_valid_in          = 1'b1;
                     rsp_data_in           = '0;
                     rsp_data_in.event_res = EV_ERROR;
                  end
               end
               default: ; // discard: ignore the byte
            endcase
         end
      end

      if (send_go) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in               = '0;
         rsp_data_in.event_res     = EV_CHANNEL;
         rsp_data_in.channel_index = 4'(rd_idx_ff);
         rsp_data_in.channel_value = mem_q_ff;
         rsp_data_in.last_of_frame = last_word;
         if (!last_word) rd_idx_in = rd_idx_ff + CH_W'(1);
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= CT_IDLE;
         phase_ff      <= PH_DISCARD;
         pos_ff        <= '0;
         sum_ff        <= '0;
         ck_low_ff     <= '0;
         last_good_ff  <= '0;
         never_good_ff <= 1'b1;
         poll_time_ff  <= '0;
         rd_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ctl_ff        <= ctl_in;
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         ck_low_ff     <= ck_low_in;
         last_good_ff  <= last_good_in;
         never_good_ff <= never_good_in;
         poll_time_ff  <= poll_time_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) item_ff <= req_data;
      low_hold_ff <= low_hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // word memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_wr_idx] <= {item_ff.byte_value, low_hold_ff};
      if (mem_rd_en) mem_q_ff <= frame_mem[rd_idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
